### hdl/samb_pkg.sv
package samb_pkg;

    // table sizes and address widths
    localparam int FINE_SINE_ENTRIES   = 2048;
    localparam int COARSE_SINE_ENTRIES = 256;
    localparam int FINE_QTR            = FINE_SINE_ENTRIES / 4;
    localparam int COARSE_QTR          = COARSE_SINE_ENTRIES / 4;
    localparam int FINE_AW             = $clog2(FINE_SINE_ENTRIES);
    localparam int FINE_QW             = $clog2(FINE_QTR);
    localparam int COARSE_AW           = $clog2(COARSE_SINE_ENTRIES);
    localparam int COARSE_QW           = $clog2(COARSE_QTR);

    // field and datapath widths
    localparam int GROUP_W   = 5;
    localparam int SCALE_W   = 16;
    localparam int ROT_W     = 11;
    localparam int MAG_W     = 9;
    localparam int TRIG_W    = 10;
    localparam int REM_W     = 17;
    localparam int QUO_W     = 17;
    localparam int INV_W     = 18;
    localparam int PROD_W    = INV_W + TRIG_W;
    localparam int Q_FRAC    = 8;
    localparam int DIV_STEPS = QUO_W;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [63:0] t_ser_div [12];
    localparam t_ser_div SER_DIV_ODD  = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
                                          64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};
    localparam t_ser_div SER_DIV_EVEN = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
                                          64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

    typedef logic [MAG_W-1:0] t_fine_tab   [FINE_QTR];
    typedef logic [MAG_W-1:0] t_coarse_tab [COARSE_QTR];

    // one divider lane: partial remainder, quotient so far, divisor magnitude
    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [QUO_W-1:0]   quo;
        logic [SCALE_W-1:0] dvs;
    } t_lane;

    // item payload carried along the divider row
    typedef struct packed {
        logic [GROUP_W-1:0]        grp;
        logic signed [SCALE_W-1:0] xs;
        logic signed [SCALE_W-1:0] ys;
        logic                      inv;
        logic                      fx;
        logic                      fy;
        logic                      keep;
        logic signed [TRIG_W-1:0]  s1;
        logic signed [TRIG_W-1:0]  c1;
        logic signed [TRIG_W-1:0]  s2;
        logic signed [TRIG_W-1:0]  c2;
    } t_item;

    typedef struct packed {
        t_item item;
        t_lane lx;
        t_lane ly;
    } t_cell_rec;

    // taylor series in q30 on [0, pi/2]: sine when odd, cosine otherwise
    function automatic logic [63:0] series_q30(logic [63:0] x, logic odd);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = odd ? x : Q30_ONE;
        sum  = $signed(term);
        for (int i = 1; i <= 12; i++) begin
            term = (term * x2) >> 30;
            term = odd ? term / SER_DIV_ODD[i-1] : term / SER_DIV_EVEN[i-1];
            if ((i & 1) != 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        return sum[63] ? 64'd0 : $unsigned(sum);
    endfunction

    function automatic logic [MAG_W-1:0] quarter_entry(logic [63:0] x, logic odd);
        logic [63:0] mag;
        logic [63:0] val;
        mag = series_q30(x, odd);
        val = (mag * 64'd256 + (Q30_ONE >> 1)) >> 30;
        return val[MAG_W-1:0];
    endfunction

    function automatic t_fine_tab fine_table(logic odd);
        t_fine_tab   tab;
        logic [63:0] x;
        for (int rq = 0; rq < FINE_QTR; rq++) begin
            x       = (64'(rq) * HALF_PI_Q30) / FINE_QTR;
            tab[rq] = quarter_entry(x, odd);
        end
        return tab;
    endfunction

    function automatic t_coarse_tab coarse_table(logic odd);
        t_coarse_tab tab;
        logic [63:0] x;
        for (int rq = 0; rq < COARSE_QTR; rq++) begin
            x       = (64'(rq) * HALF_PI_Q30) / COARSE_QTR;
            tab[rq] = quarter_entry(x, odd);
        end
        return tab;
    endfunction

endpackage

### hdl/samb_trig_rom.sv
module samb_trig_rom (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [samb_pkg::ROT_W-1:0]            i_rotation,
    input  logic                                  i_fine,
    input  logic                                  i_negate,
    output logic signed [samb_pkg::TRIG_W-1:0]    o_sin,
    output logic signed [samb_pkg::TRIG_W-1:0]    o_cos
);

    localparam samb_pkg::t_fine_tab   FINE_SIN   = samb_pkg::fine_table(1'b1);
    localparam samb_pkg::t_fine_tab   FINE_COS   = samb_pkg::fine_table(1'b0);
    localparam samb_pkg::t_coarse_tab COARSE_SIN = samb_pkg::coarse_table(1'b1);
    localparam samb_pkg::t_coarse_tab COARSE_COS = samb_pkg::coarse_table(1'b0);

    localparam logic [1:0] QTR_0 = 2'd0;
    localparam logic [1:0] QTR_1 = 2'd1;
    localparam logic [1:0] QTR_2 = 2'd2;
    localparam logic [1:0] QTR_3 = 2'd3;

    logic [samb_pkg::FINE_AW-1:0]   fine_ang;
    logic [samb_pkg::COARSE_AW-1:0] coarse_ang;
    logic [samb_pkg::MAG_W-1:0]     r_fine_sin;
    logic [samb_pkg::MAG_W-1:0]     r_fine_cos;
    logic [samb_pkg::MAG_W-1:0]     r_coarse_sin;
    logic [samb_pkg::MAG_W-1:0]     r_coarse_cos;
    logic [1:0]                     r_quarter;
    logic                           r_fine;
    logic signed [samb_pkg::TRIG_W-1:0] ps;
    logic signed [samb_pkg::TRIG_W-1:0] pc;

    // angle negation is a wrap-around subtract from zero
    always_comb begin
        fine_ang   = i_rotation[samb_pkg::FINE_AW-1:0];
        coarse_ang = i_rotation[samb_pkg::COARSE_AW-1:0];
        if (i_negate) begin
            fine_ang   = samb_pkg::FINE_AW'(0) - fine_ang;
            coarse_ang = samb_pkg::COARSE_AW'(0) - coarse_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fine_sin   <= FINE_SIN[fine_ang[samb_pkg::FINE_QW-1:0]];
            r_fine_cos   <= FINE_COS[fine_ang[samb_pkg::FINE_QW-1:0]];
            r_coarse_sin <= COARSE_SIN[coarse_ang[samb_pkg::COARSE_QW-1:0]];
            r_coarse_cos <= COARSE_COS[coarse_ang[samb_pkg::COARSE_QW-1:0]];
            r_quarter    <= i_fine ? fine_ang[samb_pkg::FINE_AW-1 -: 2]
                                   : coarse_ang[samb_pkg::COARSE_AW-1 -: 2];
            r_fine       <= i_fine;
        end
    end

    always_comb begin
        ps = $signed({1'b0, r_fine ? r_fine_sin : r_coarse_sin});
        pc = $signed({1'b0, r_fine ? r_fine_cos : r_coarse_cos});
        unique case (r_quarter)
            QTR_0: begin
                o_sin = ps;
                o_cos = pc;
            end
            QTR_1: begin
                o_sin = pc;
                o_cos = -ps;
            end
            QTR_2: begin
                o_sin = -ps;
                o_cos = -pc;
            end
            QTR_3: begin
                o_sin = -pc;
                o_cos = ps;
            end
            default: begin
                o_sin = ps;
                o_cos = pc;
            end
        endcase
    end

endmodule

### hdl/samb_div_cell.sv
module samb_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  samb_pkg::t_cell_rec  i_rec,
    output logic                 o_valid,
    output samb_pkg::t_cell_rec  o_rec
);

    logic                r_valid;
    samb_pkg::t_cell_rec r_rec;
    samb_pkg::t_cell_rec n_rec;

    // one restoring step: compare, subtract, shift in the next zero bit
    function automatic samb_pkg::t_lane step(samb_pkg::t_lane l);
        samb_pkg::t_lane            o;
        logic [samb_pkg::REM_W-1:0] diff;
        logic                       hit;
        hit   = l.rem >= {1'b0, l.dvs};
        diff  = hit ? l.rem - {1'b0, l.dvs} : l.rem;
        o.rem = {diff[samb_pkg::REM_W-2:0], 1'b0};
        o.quo = {l.quo[samb_pkg::QUO_W-2:0], hit};
        o.dvs = l.dvs;
        return o;
    endfunction

    always_comb begin
        n_rec      = i_rec;
        n_rec.lx   = step(i_rec.lx);
        n_rec.ly   = step(i_rec.ly);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rec <= n_rec;
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;

endmodule

### hdl/samb_mat_unit.sv
module samb_mat_unit (
    input  logic signed [samb_pkg::INV_W-1:0]   i_sx,
    input  logic signed [samb_pkg::INV_W-1:0]   i_sy,
    input  logic signed [samb_pkg::TRIG_W-1:0]  i_sin,
    input  logic signed [samb_pkg::TRIG_W-1:0]  i_cos,
    input  logic                                i_second,
    output logic signed [samb_pkg::SCALE_W-1:0] o_a,
    output logic signed [samb_pkg::SCALE_W-1:0] o_b,
    output logic signed [samb_pkg::SCALE_W-1:0] o_c,
    output logic signed [samb_pkg::SCALE_W-1:0] o_d
);

    logic signed [samb_pkg::INV_W-1:0]  b_scale;
    logic signed [samb_pkg::INV_W-1:0]  c_scale;
    logic signed [samb_pkg::TRIG_W-1:0] nsin;
    logic signed [samb_pkg::PROD_W-1:0] pa;
    logic signed [samb_pkg::PROD_W-1:0] pb;
    logic signed [samb_pkg::PROD_W-1:0] pc;
    logic signed [samb_pkg::PROD_W-1:0] pd;

    // renderer form swaps the scales on the off-diagonal
    assign b_scale = i_second ? i_sy : i_sx;
    assign c_scale = i_second ? i_sx : i_sy;
    assign nsin    = -i_sin;

    assign pa = samb_pkg::PROD_W'(i_sx) * samb_pkg::PROD_W'(i_cos);
    assign pb = samb_pkg::PROD_W'(b_scale) * samb_pkg::PROD_W'(nsin);
    assign pc = samb_pkg::PROD_W'(c_scale) * samb_pkg::PROD_W'(i_sin);
    assign pd = samb_pkg::PROD_W'(i_sy) * samb_pkg::PROD_W'(i_cos);

    // arithmetic shift by the fraction width, wrapped to 16 bits
    assign o_a = pa[samb_pkg::Q_FRAC +: samb_pkg::SCALE_W];
    assign o_b = pb[samb_pkg::Q_FRAC +: samb_pkg::SCALE_W];
    assign o_c = pc[samb_pkg::Q_FRAC +: samb_pkg::SCALE_W];
    assign o_d = pd[samb_pkg::Q_FRAC +: samb_pkg::SCALE_W];

endmodule

### hdl/sprite_affine_matrix_builder_core.sv
// sprite_affine_matrix_builder_core
// builds two q8.8 rotation/scale 2x2 matrices for a sprite group
// input channel: i_valid / o_stall with the item fields as separate ports;
//   a beat is taken at a rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall; a beat leaves at an edge with o_valid
//   high and i_stall low, fields hold while stalled
// path from input beat to o_valid: trig rom read, 17 divider cells, scale
//   select, multiply, flip and output register
// throughput: one beat per cycle while i_stall is low; the inverse scale
//   65536/scale comes from a row of 17 divider cells, one quotient bit per
//   cell, so every stage can hold a different item
// each stage advances whenever it is empty or the stage after it advances;
//   with i_stall high, bubbles still close up and new beats keep entering
//   until every stage holds an item, then o_stall rises
// reset (synchronous, active low) empties every stage; no table needs filling
module sprite_affine_matrix_builder_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [samb_pkg::GROUP_W-1:0]          i_group_index,
    input  logic signed [samb_pkg::SCALE_W-1:0]   i_x_scale,
    input  logic signed [samb_pkg::SCALE_W-1:0]   i_y_scale,
    input  logic [samb_pkg::ROT_W-1:0]            i_rotation,
    input  logic                                  i_invert_first,
    input  logic                                  i_flip_x,
    input  logic                                  i_flip_y,
    input  logic                                  i_fine_angle,
    input  logic                                  i_keep_second,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [samb_pkg::GROUP_W-1:0]          o_group_out,
    output logic signed [samb_pkg::SCALE_W-1:0]   o_first_a,
    output logic signed [samb_pkg::SCALE_W-1:0]   o_first_b,
    output logic signed [samb_pkg::SCALE_W-1:0]   o_first_c,
    output logic signed [samb_pkg::SCALE_W-1:0]   o_first_d,
    output logic signed [samb_pkg::SCALE_W-1:0]   o_second_a,
    output logic signed [samb_pkg::SCALE_W-1:0]   o_second_b,
    output logic signed [samb_pkg::SCALE_W-1:0]   o_second_c,
    output logic signed [samb_pkg::SCALE_W-1:0]   o_second_d,
    output logic                                  o_second_valid,
    output logic                                  o_zero_scale
);

    // stage numbering: 0 rom/capture, 1..17 divider cells, then finish,
    // multiply and output
    localparam int ST_FIN = samb_pkg::DIV_STEPS + 1;
    localparam int ST_MUL = ST_FIN + 1;
    localparam int ST_OUT = ST_MUL + 1;
    localparam int N_ST   = ST_OUT + 1;

    localparam int W  = samb_pkg::SCALE_W;
    localparam int IW = samb_pkg::INV_W;
    localparam int TW = samb_pkg::TRIG_W;

    typedef struct packed {
        logic [samb_pkg::GROUP_W-1:0] grp;
        logic                         inv;
        logic                         fx;
        logic                         fy;
        logic                         keep;
        logic                         zero;
        logic signed [IW-1:0]         sx1;
        logic signed [IW-1:0]         sy1;
        logic signed [IW-1:0]         sx2;
        logic signed [IW-1:0]         sy2;
        logic signed [TW-1:0]         s1;
        logic signed [TW-1:0]         c1;
        logic signed [TW-1:0]         s2;
        logic signed [TW-1:0]         c2;
    } t_fin_rec;

    typedef struct packed {
        logic [samb_pkg::GROUP_W-1:0] grp;
        logic                         fx;
        logic                         fy;
        logic                         keep;
        logic                         zero;
        logic signed [W-1:0]          fa;
        logic signed [W-1:0]          fb;
        logic signed [W-1:0]          fc;
        logic signed [W-1:0]          fd;
        logic signed [W-1:0]          sa;
        logic signed [W-1:0]          sb;
        logic signed [W-1:0]          sc;
        logic signed [W-1:0]          sd;
    } t_mul_rec;

    logic [N_ST-1:0] stage_v;
    logic [N_ST-1:0] rdy;

    // stage 0 registers beside the rom read
    logic                         r_v0;
    samb_pkg::t_item              r_s0;
    samb_pkg::t_lane              r_lx0;
    samb_pkg::t_lane              r_ly0;
    logic signed [TW-1:0]         rom1_sin;
    logic signed [TW-1:0]         rom1_cos;
    logic signed [TW-1:0]         rom2_sin;
    logic signed [TW-1:0]         rom2_cos;

    samb_pkg::t_cell_rec          cell_rec [samb_pkg::DIV_STEPS+1];
    logic [samb_pkg::DIV_STEPS:0] cell_v;

    logic                 r_v_fin;
    t_fin_rec             r_fin;
    t_fin_rec             n_fin;
    logic                 r_v_mul;
    t_mul_rec             r_mul;
    t_mul_rec             n_mul;
    logic                 r_v_out;
    t_mul_rec             r_out;
    t_mul_rec             n_out;
    logic signed [IW-1:0] ix;
    logic signed [IW-1:0] iy;

    // ---------------------------------------------------------------------
    // stage occupancy and advance chain: a stage moves when it is empty or
    // its successor moves, so any bubble in the row lets the stages before
    // it close up; o_stall follows i_stall only once every stage is full
    // ---------------------------------------------------------------------
    assign stage_v[0] = r_v0;
    genvar g;
    generate
        for (g = 1; g <= samb_pkg::DIV_STEPS; g++) begin : g_sv
            assign stage_v[g] = cell_v[g];
        end
    endgenerate
    assign stage_v[ST_FIN] = r_v_fin;
    assign stage_v[ST_MUL] = r_v_mul;
    assign stage_v[ST_OUT] = r_v_out;

    assign rdy[ST_OUT] = !stage_v[ST_OUT] || !i_stall;
    generate
        for (g = 0; g < ST_OUT; g++) begin : g_rdy
            assign rdy[g] = !stage_v[g] || rdy[g+1];
        end
    endgenerate

    assign o_stall = !rdy[0];

    // ---------------------------------------------------------------------
    // stage 0: capture the beat, read sin/cos for both angles; the first
    // matrix angle is negated when exactly one flip bit is set
    // ---------------------------------------------------------------------
    samb_trig_rom u_rom_first (
        .i_clk      (i_clk),
        .i_en       (rdy[0]),
        .i_rotation (i_rotation),
        .i_fine     (i_fine_angle),
        .i_negate   (i_flip_x ^ i_flip_y),
        .o_sin      (rom1_sin),
        .o_cos      (rom1_cos)
    );

    samb_trig_rom u_rom_second (
        .i_clk      (i_clk),
        .i_en       (rdy[0]),
        .i_rotation (i_rotation),
        .i_fine     (i_fine_angle),
        .i_negate   (1'b0),
        .o_sin      (rom2_sin),
        .o_cos      (rom2_cos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (rdy[0]) begin
            r_v0 <= i_valid;
        end
    end

    // divider lanes start with the leading dividend bit already shifted in;
    // the magnitude of -32768 is 32768, which fits the unsigned lane
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s0.grp  <= i_group_index;
            r_s0.xs   <= i_x_scale;
            r_s0.ys   <= i_y_scale;
            r_s0.inv  <= i_invert_first;
            r_s0.fx   <= i_flip_x;
            r_s0.fy   <= i_flip_y;
            r_s0.keep <= i_keep_second;
            r_s0.s1   <= '0;
            r_s0.c1   <= '0;
            r_s0.s2   <= '0;
            r_s0.c2   <= '0;
            r_lx0.rem <= samb_pkg::REM_W'(1);
            r_lx0.quo <= '0;
            r_lx0.dvs <= i_x_scale[W-1] ? W'(-i_x_scale) : W'(i_x_scale);
            r_ly0.rem <= samb_pkg::REM_W'(1);
            r_ly0.quo <= '0;
            r_ly0.dvs <= i_y_scale[W-1] ? W'(-i_y_scale) : W'(i_y_scale);
        end
    end

    always_comb begin
        cell_rec[0]         = '{item: r_s0, lx: r_lx0, ly: r_ly0};
        cell_rec[0].item.s1 = rom1_sin;
        cell_rec[0].item.c1 = rom1_cos;
        cell_rec[0].item.s2 = rom2_sin;
        cell_rec[0].item.c2 = rom2_cos;
    end
    assign cell_v[0] = r_v0;

    // ---------------------------------------------------------------------
    // divider row: one quotient bit per cell, msb first
    // ---------------------------------------------------------------------
    generate
        for (g = 1; g <= samb_pkg::DIV_STEPS; g++) begin : g_cell
            samb_div_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (rdy[g]),
                .i_valid (cell_v[g-1]),
                .i_rec   (cell_rec[g-1]),
                .o_valid (cell_v[g]),
                .o_rec   (cell_rec[g])
            );
        end
    endgenerate

    // ---------------------------------------------------------------------
    // finish: sign the quotients, zero divisor gives zero, pick which matrix
    // takes the inverse scales
    // ---------------------------------------------------------------------
    function automatic logic signed [IW-1:0] signed_inverse(
        logic signed [W-1:0]          s,
        logic [samb_pkg::QUO_W-1:0]   q
    );
        logic signed [IW-1:0] mag;
        mag = $signed({1'b0, q});
        if (s == '0) begin
            return '0;
        end else if (s[W-1]) begin
            return -mag;
        end
        return mag;
    endfunction

    always_comb begin
        ix          = signed_inverse(cell_rec[samb_pkg::DIV_STEPS].item.xs,
                                     cell_rec[samb_pkg::DIV_STEPS].lx.quo);
        iy          = signed_inverse(cell_rec[samb_pkg::DIV_STEPS].item.ys,
                                     cell_rec[samb_pkg::DIV_STEPS].ly.quo);
        n_fin.grp   = cell_rec[samb_pkg::DIV_STEPS].item.grp;
        n_fin.inv   = cell_rec[samb_pkg::DIV_STEPS].item.inv;
        n_fin.fx    = cell_rec[samb_pkg::DIV_STEPS].item.fx;
        n_fin.fy    = cell_rec[samb_pkg::DIV_STEPS].item.fy;
        n_fin.keep  = cell_rec[samb_pkg::DIV_STEPS].item.keep;
        n_fin.zero  = (n_fin.inv || n_fin.keep)
                      && (cell_rec[samb_pkg::DIV_STEPS].item.xs == '0
                          || cell_rec[samb_pkg::DIV_STEPS].item.ys == '0);
        n_fin.sx1   = n_fin.inv ? ix : IW'(cell_rec[samb_pkg::DIV_STEPS].item.xs);
        n_fin.sy1   = n_fin.inv ? iy : IW'(cell_rec[samb_pkg::DIV_STEPS].item.ys);
        n_fin.sx2   = n_fin.inv ? IW'(cell_rec[samb_pkg::DIV_STEPS].item.xs) : ix;
        n_fin.sy2   = n_fin.inv ? IW'(cell_rec[samb_pkg::DIV_STEPS].item.ys) : iy;
        n_fin.s1    = cell_rec[samb_pkg::DIV_STEPS].item.s1;
        n_fin.c1    = cell_rec[samb_pkg::DIV_STEPS].item.c1;
        n_fin.s2    = cell_rec[samb_pkg::DIV_STEPS].item.s2;
        n_fin.c2    = cell_rec[samb_pkg::DIV_STEPS].item.c2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_fin <= 1'b0;
        end else if (rdy[ST_FIN]) begin
            r_v_fin <= cell_v[samb_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[ST_FIN]) begin
            r_fin <= n_fin;
        end
    end

    // ---------------------------------------------------------------------
    // multiply: both matrices side by side, products wrapped to 16 bits
    // ---------------------------------------------------------------------
    samb_mat_unit u_mat_first (
        .i_sx     (r_fin.sx1),
        .i_sy     (r_fin.sy1),
        .i_sin    (r_fin.s1),
        .i_cos    (r_fin.c1),
        .i_second (1'b0),
        .o_a      (n_mul.fa),
        .o_b      (n_mul.fb),
        .o_c      (n_mul.fc),
        .o_d      (n_mul.fd)
    );

    samb_mat_unit u_mat_second (
        .i_sx     (r_fin.sx2),
        .i_sy     (r_fin.sy2),
        .i_sin    (r_fin.s2),
        .i_cos    (r_fin.c2),
        .i_second (1'b1),
        .o_a      (n_mul.sa),
        .o_b      (n_mul.sb),
        .o_c      (n_mul.sc),
        .o_d      (n_mul.sd)
    );

    assign n_mul.grp  = r_fin.grp;
    assign n_mul.fx   = r_fin.fx;
    assign n_mul.fy   = r_fin.fy;
    assign n_mul.keep = r_fin.keep;
    assign n_mul.zero = r_fin.zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mul <= 1'b0;
        end else if (rdy[ST_MUL]) begin
            r_v_mul <= r_v_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[ST_MUL]) begin
            r_mul <= n_mul;
        end
    end

    // ---------------------------------------------------------------------
    // output: flip x negates a and c, flip y negates b and d; the renderer
    // matrix reads as zero when it was not asked for
    // ---------------------------------------------------------------------
    always_comb begin
        n_out    = r_mul;
        n_out.fa = r_mul.fx ? -r_mul.fa : r_mul.fa;
        n_out.fc = r_mul.fx ? -r_mul.fc : r_mul.fc;
        n_out.fb = r_mul.fy ? -r_mul.fb : r_mul.fb;
        n_out.fd = r_mul.fy ? -r_mul.fd : r_mul.fd;
        n_out.sa = r_mul.fx ? -r_mul.sa : r_mul.sa;
        n_out.sc = r_mul.fx ? -r_mul.sc : r_mul.sc;
        n_out.sb = r_mul.fy ? -r_mul.sb : r_mul.sb;
        n_out.sd = r_mul.fy ? -r_mul.sd : r_mul.sd;
        if (!r_mul.keep) begin
            n_out.sa = '0;
            n_out.sb = '0;
            n_out.sc = '0;
            n_out.sd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_out <= 1'b0;
        end else if (rdy[ST_OUT]) begin
            r_v_out <= r_v_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_v_out;
    assign o_group_out    = r_out.grp;
    assign o_first_a      = r_out.fa;
    assign o_first_b      = r_out.fb;
    assign o_first_c      = r_out.fc;
    assign o_first_d      = r_out.fd;
    assign o_second_a     = r_out.sa;
    assign o_second_b     = r_out.sb;
    assign o_second_c     = r_out.sc;
    assign o_second_d     = r_out.sd;
    assign o_second_valid = r_out.keep;
    assign o_zero_scale   = r_out.zero;

`ifndef NO_ASSERTIONS
    // zero-scale flag only where an inverse was needed
    a_zero_needs_inverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_fin && !r_fin.inv && !r_fin.keep |-> !r_fin.zero)
        else $error("zero scale flagged without an inverse");

    // unity scale must invert to unity through the divider row
    a_unity_inverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_fin && r_fin.inv && r_fin.sx2 == IW'(256) |-> r_fin.sx1 == IW'(256))
        else $error("divider row gave a wrong inverse of unity");

    // a held item is never dropped while its successor is blocked
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_fin && !rdy[ST_FIN] |=> r_v_fin && $stable(r_fin))
        else $error("finish stage lost a blocked item");

    // renderer fields are zero when not requested
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_second_valid |-> o_second_a == '0 && o_second_b == '0
                                      && o_second_c == '0 && o_second_d == '0)
        else $error("renderer matrix present without request");
`endif

endmodule

### dv/sprite_affine_matrix_checker.sv
module sprite_affine_matrix_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic [samb_pkg::GROUP_W-1:0]      i_group_index,
    input  logic signed [samb_pkg::SCALE_W-1:0] i_x_scale,
    input  logic signed [samb_pkg::SCALE_W-1:0] i_y_scale,
    input  logic [samb_pkg::ROT_W-1:0]        i_rotation,
    input  logic                              i_invert_first,
    input  logic                              i_flip_x,
    input  logic                              i_flip_y,
    input  logic                              i_fine_angle,
    input  logic                              i_keep_second,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic [samb_pkg::GROUP_W-1:0]      o_group_out,
    input  logic signed [samb_pkg::SCALE_W-1:0] o_first_a,
    input  logic signed [samb_pkg::SCALE_W-1:0] o_first_b,
    input  logic signed [samb_pkg::SCALE_W-1:0] o_first_c,
    input  logic signed [samb_pkg::SCALE_W-1:0] o_first_d,
    input  logic signed [samb_pkg::SCALE_W-1:0] o_second_a,
    input  logic signed [samb_pkg::SCALE_W-1:0] o_second_b,
    input  logic signed [samb_pkg::SCALE_W-1:0] o_second_c,
    input  logic signed [samb_pkg::SCALE_W-1:0] o_second_d,
    input  logic                              o_second_valid,
    input  logic                              o_zero_scale,
    output int                                o_fail_count,
    output int                                o_pending
);
    localparam longint unsigned ONE_Q30  = 64'd1073741824;
    localparam longint unsigned QPI_Q30  = 64'd1686629713;
    localparam int              N_GROUPS = 32;

    typedef struct packed {
        logic [4:0]       grp;
        logic [7:0][15:0] elem;   // first a..d in 0..3, second a..d in 4..7
        logic             second_ok;
        logic             zero;
    } t_matrices;

    t_matrices exp_q[$];

    // power series on [0, pi/2], odd terms give sine, even give cosine
    function automatic longint unsigned poly_q30(longint unsigned x, bit odd);
        longint unsigned x2, term, k;
        longint          acc;
        x2   = (x * x) >> 30;
        term = odd ? x : ONE_Q30;
        acc  = longint'(term);
        k    = odd ? 1 : 0;
        for (int i = 1; i <= 12; i++) begin
            term = (term * x2) >> 30;
            term = term / ((k + 1) * (k + 2));
            k += 2;
            if (i % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        return (acc < 0) ? 0 : longint'(acc);
    endfunction

    // round(256*sin(u*(pi/2)/n))
    function automatic int sin_units(int unsigned u, int unsigned n);
        int unsigned     quad, r;
        longint unsigned x, mag, v;
        u    = u % (4 * n);
        quad = u / n;
        r    = u % n;
        x    = (longint'(r) * QPI_Q30) / n;
        mag  = poly_q30(x, quad[0] == 1'b0);
        v    = (mag * 256 + (ONE_Q30 >> 1)) >> 30;
        return (quad >= 2) ? -int'(v) : int'(v);
    endfunction

    function automatic void angle_trig(bit fine, int unsigned rot, bit neg,
                                       output int s, output int c);
        int unsigned n, a;
        n = fine ? samb_pkg::FINE_SINE_ENTRIES : samb_pkg::COARSE_SINE_ENTRIES;
        a = rot % n;
        if (neg) a = (n - a) % n;
        s = sin_units(4 * a, n);
        if (fine) c = sin_units(4 * ((a + n / 4) % n), n);
        else c = sin_units(4 * a + n, n);
    endfunction

    function automatic logic [15:0] q8_mul(int scale, int trig);
        longint p;
        p = longint'(scale) * longint'(trig);
        p = p >>> 8;
        return p[15:0];
    endfunction

    function automatic logic [3:0][15:0] rot_scale(int sx, int sy, int s, int c,
                                                   bit second, bit fx, bit fy);
        logic [3:0][15:0] m;
        m[0] = q8_mul(sx, c);
        m[1] = q8_mul(second ? sy : sx, -s);
        m[2] = q8_mul(second ? sx : sy, s);
        m[3] = q8_mul(sy, c);
        if (fx) begin
            m[0] = -m[0];
            m[2] = -m[2];
        end
        if (fy) begin
            m[1] = -m[1];
            m[3] = -m[3];
        end
        return m;
    endfunction

    function automatic t_matrices predict_matrices();
        t_matrices        r;
        int               xs, ys, ix, iy, s, c;
        logic [3:0][15:0] m;
        xs = i_x_scale;
        ys = i_y_scale;
        ix = 0;
        iy = 0;
        r  = '0;
        r.grp = i_group_index;
        if (i_invert_first || i_keep_second) begin
            r.zero = (xs == 0) || (ys == 0);
            ix = (xs != 0) ? 65536 / xs : 0;
            iy = (ys != 0) ? 65536 / ys : 0;
        end
        angle_trig(i_fine_angle, i_rotation, i_flip_x != i_flip_y, s, c);
        m = rot_scale(i_invert_first ? ix : xs, i_invert_first ? iy : ys, s, c,
                      1'b0, i_flip_x, i_flip_y);
        r.elem[3:0] = m;
        if (i_keep_second) begin
            angle_trig(i_fine_angle, i_rotation, 1'b0, s, c);
            m = rot_scale(i_invert_first ? xs : ix, i_invert_first ? ys : iy, s, c,
                          1'b1, i_flip_x, i_flip_y);
            r.elem[7:4] = m;
            r.second_ok = 1'b1;
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("mismatch %s: expected %0h got %0h", what, want, got);
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_matrices        w;
        logic [7:0][15:0] got;
        string            nm [8];
        nm = '{"first_a", "first_b", "first_c", "first_d",
               "second_a", "second_b", "second_c", "second_d"};
        if (i_rst_n) begin
            if (i_valid && !o_stall && i_group_index < N_GROUPS)
                exp_q.push_back(predict_matrices());
            if (o_valid && !i_stall) begin
                if (exp_q.size() == 0) begin
                    note_mismatch("unexpected beat", 16'h0, 16'(o_group_out));
                end else begin
                    w   = exp_q.pop_front();
                    got = {o_second_d, o_second_c, o_second_b, o_second_a,
                           o_first_d, o_first_c, o_first_b, o_first_a};
                    if (w.grp !== o_group_out)
                        note_mismatch("group_out", 16'(w.grp), 16'(o_group_out));
                    for (int i = 0; i < 8; i++)
                        if (w.elem[i] !== got[i]) note_mismatch(nm[i], w.elem[i], got[i]);
                    if (w.second_ok !== o_second_valid)
                        note_mismatch("second_valid", 16'(w.second_ok),
                                      16'(o_second_valid));
                    if (w.zero !== o_zero_scale)
                        note_mismatch("zero_scale", 16'(w.zero), 16'(o_zero_scale));
                end
            end
        end
        o_pending = exp_q.size();
    end
endmodule

### dv/sprite_affine_matrix_builder_core_tb.sv
module sprite_affine_matrix_builder_core_tb;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BEATS   = 1500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [4:0]  i_group_index = '0;
    logic signed [15:0] i_x_scale = '0;
    logic signed [15:0] i_y_scale = '0;
    logic [10:0] i_rotation = '0;
    logic        i_invert_first = 1'b0;
    logic        i_flip_x = 1'b0;
    logic        i_flip_y = 1'b0;
    logic        i_fine_angle = 1'b0;
    logic        i_keep_second = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [4:0]  o_group_out;
    logic signed [15:0] o_first_a, o_first_b, o_first_c, o_first_d;
    logic signed [15:0] o_second_a, o_second_b, o_second_c, o_second_d;
    logic        o_second_valid;
    logic        o_zero_scale;
    int          fail_count;
    int          pending;
    int          beats_sent = 0;
    int          beats_out = 0;
    int          idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    sprite_affine_matrix_builder_core dut (.*);

    sprite_affine_matrix_checker u_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // receiver stall pattern: mode rotates through four settings, from never to heavy
    always @(posedge i_clk) begin
        int unsigned mode;
        mode = 32'(($time / 3000) % 4);
        case (mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(99) < 30);
            end
            2: begin
                i_stall <= ($urandom_range(99) < 75);
            end
            default: begin
                i_stall <= ((($time / 20) % 16) >= 11);
            end
        endcase
    end

    // watchdog: any beat on either side resets the idle count
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) beats_out++;
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // present one beat and hold it until the block takes it
    task automatic send_beat(logic [4:0] grp, logic [15:0] xs, logic [15:0] ys,
                             logic [10:0] rot, logic [4:0] modes);
        i_valid        <= 1'b1;
        i_group_index  <= grp;
        i_x_scale      <= xs;
        i_y_scale      <= ys;
        i_rotation     <= rot;
        i_invert_first <= modes[0];
        i_flip_x       <= modes[1];
        i_flip_y       <= modes[2];
        i_fine_angle   <= modes[3];
        i_keep_second  <= modes[4];
        do @(posedge i_clk); while (o_stall);
        beats_sent++;
    endtask

    task automatic go_idle(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        go_idle(1);
        while (pending != 0) @(posedge i_clk);
    endtask

    // scale picks lean on zero, unity, tiny and extreme values
    function automatic logic [15:0] pick_scale();
        logic [15:0] edge_vals [10];
        edge_vals = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                      16'h0100, 16'hFF00, 16'h0080, 16'h0002, 16'hFFFE};
        if ($urandom_range(99) < 20) return edge_vals[$urandom_range(9)];
        if ($urandom_range(99) < 50) return 16'($signed($urandom_range(1024)) - 512);
        return 16'($urandom);
    endfunction

    initial begin
        logic [15:0] dir_scale [7];
        logic [10:0] dir_rot [7];
        int          burst;
        dir_scale = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0100, 16'hFF00};
        dir_rot   = '{11'd0, 11'd512, 11'd1024, 11'd1536, 11'd2047, 11'd255, 11'd64};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every mode combination at least once, extremes of scale and angle
        for (int m = 0; m < 32; m++)
            send_beat(m[4:0] == 0 ? 5'd0 : 5'd31, dir_scale[m % 7], dir_scale[(m + 3) % 7],
                      dir_rot[m % 7], m[4:0]);
        send_beat(5'd17, 16'h0000, 16'h0000, 11'h7FF, 5'b11111);
        send_beat(5'd3, 16'h8000, 16'h8000, 11'd1024, 5'b10110);
        send_beat(5'd9, 16'h0001, 16'h0100, 11'd128, 5'b00000);
        send_beat(5'd1, 16'h0000, 16'h0040, 11'd300, 5'b00001);
        drain_results();

        // random bursts, most of them separated by random gaps
        while (beats_sent < RANDOM_BEATS + 20) begin
            burst = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
            repeat (burst)
                send_beat(5'($urandom), pick_scale(), pick_scale(), 11'($urandom),
                          5'($urandom));
            if ($urandom_range(9) < 6) go_idle($urandom_range(6, 1));
            if ($urandom_range(99) == 0) drain_results();
        end
        drain_results();
        repeat (30) @(posedge i_clk);

        $display("sent %0d beats (all mode combinations, edge scales and angles),",
                 beats_sent);
        $display("checked %0d result beats under mixed input gaps and output stalls",
                 beats_out);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

### sim.f
hdl/samb_pkg.sv
hdl/samb_trig_rom.sv
hdl/samb_div_cell.sv
hdl/samb_mat_unit.sv
hdl/sprite_affine_matrix_builder_core.sv
dv/sprite_affine_matrix_checker.sv
dv/sprite_affine_matrix_builder_core_tb.sv
